// ===== hdl/olst_pkg.sv =====
// ----------------------------------------------------------------------------
// olst_pkg
// Types and codes shared by the ordered array list block.
// ----------------------------------------------------------------------------
package olst_pkg;

    localparam logic [2:0] OP_INSERT      = 3'd0;
    localparam logic [2:0] OP_INSERT_BACK = 3'd1;
    localparam logic [2:0] OP_REMOVE      = 3'd2;
    localparam logic [2:0] OP_REMOVE_BACK = 3'd3;
    localparam logic [2:0] OP_REPLACE     = 3'd4;
    localparam logic [2:0] OP_SELECT      = 3'd5;
    localparam logic [2:0] OP_SEARCH      = 3'd6;

    localparam int RES_CNT_W = 7;

    typedef struct packed {
        logic [2:0]         operation;
        logic [5:0]         position;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic                 ok;
        logic signed [31:0]   read_value;
        logic [RES_CNT_W-1:0] found_index;
        logic [RES_CNT_W-1:0] element_total;
        logic                 is_empty;
        logic                 is_full;
    } t_res;

    typedef struct packed {
        logic load;
        logic init_up;
        logic init_dn;
        logic init_scan;
        logic rd_sel;
        logic step_up;
        logic step_dn;
        logic step_scan;
        logic wr_word;
        logic cnt_inc;
        logic cnt_dec;
        logic finish;
        logic ok;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       ins_ok;
        logic       rem_ok;
        logic       idx_ok;
        logic       up_more;
        logic       dn_more;
        logic       scan_more;
        logic       scan_hit;
    } t_stat;

endpackage

// ===== hdl/olst_ram.sv =====
// ----------------------------------------------------------------------------
// olst_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module olst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/olst_dpath.sv =====
// ----------------------------------------------------------------------------
// olst_dpath
// List datapath: request registers, entry count, walk pointer, entry RAM
// and result register. Steps are driven by the controller.
// ----------------------------------------------------------------------------
module olst_dpath
    import olst_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_req  i_req,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output logic  o_strobe,
    output t_res  o_res
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = ((CNT_W > RES_CNT_W) ? CNT_W : RES_CNT_W) + 1;
    localparam int XW     = (WORD_BITS > 32) ? WORD_BITS : 32;

    logic [2:0]           r_op;
    logic [5:0]           r_pos;
    logic [WORD_BITS-1:0] r_word;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [CNT_W-1:0]     r_ptr;
    logic [CNT_W-1:0]     r_scan_idx;
    logic [ADDR_W-1:0]    r_wr_addr;
    logic                 r_rd_pend;
    logic                 r_strobe;
    t_res                 r_res;

    logic signed [XW-1:0] vx;
    logic [XW-1:0]        rx;
    logic [CMP_W-1:0]     x_pos;
    logic [CMP_W-1:0]     x_cnt;
    logic [CMP_W-1:0]     x_cap;
    logic [CMP_W-1:0]     x_ptr;
    logic [CMP_W-1:0]     x_epos;
    logic [CMP_W-1:0]     x_ptr_dec;
    logic [CMP_W-1:0]     x_ptr_inc;
    logic [CMP_W-1:0]     x_cnt_dec;
    logic [CMP_W-1:0]     x_found;
    logic [CMP_W-1:0]     x_total;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic ins_ok, rem_ok, idx_ok, up_more, dn_more, scan_more, scan_hit;

    assign vx        = XW'(i_req.value);
    assign rx        = XW'(ram_rdata);
    assign x_pos     = CMP_W'(r_pos);
    assign x_cnt     = CMP_W'(r_count);
    assign x_cap     = CMP_W'(CAPACITY);
    assign x_ptr     = CMP_W'(r_ptr);
    assign x_ptr_dec = x_ptr - CMP_W'(1);
    assign x_ptr_inc = x_ptr + CMP_W'(1);
    assign x_cnt_dec = x_cnt - CMP_W'(1);

    always_comb begin
        case (r_op)
            OP_INSERT_BACK: begin
                x_epos = x_cnt;
            end
            OP_REMOVE_BACK: begin
                x_epos = x_cnt_dec;
            end
            default: begin
                x_epos = x_pos;
            end
        endcase
    end

    assign ins_ok    = (x_epos < x_cap) && (x_epos <= x_cnt) && (x_cnt < x_cap);
    assign rem_ok    = (r_op == OP_REMOVE_BACK) ? (x_cnt != '0) : (x_pos < x_cnt);
    assign idx_ok    = x_pos < x_cnt;
    assign up_more   = x_ptr > x_epos;
    assign dn_more   = x_ptr_inc < x_cnt;
    assign scan_more = x_ptr < x_cnt;
    assign scan_hit  = r_rd_pend && (ram_rdata == r_word);

    assign o_stat = '{op: r_op, ins_ok: ins_ok, rem_ok: rem_ok, idx_ok: idx_ok,
                      up_more: up_more, dn_more: dn_more, scan_more: scan_more,
                      scan_hit: scan_hit};

    // pending shift beat writes the word read by the previous step
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wr_addr;
        ram_wdata = ram_rdata;
        ram_raddr = r_ptr[ADDR_W-1:0];
        if ((i_cmd.step_up || i_cmd.step_dn) && r_rd_pend) begin
            ram_we = 1'b1;
        end
        if (i_cmd.wr_word) begin
            ram_we    = 1'b1;
            ram_waddr = x_epos[ADDR_W-1:0];
            ram_wdata = r_word;
        end
        if (i_cmd.step_up) begin
            ram_raddr = x_ptr_dec[ADDR_W-1:0];
        end else if (i_cmd.step_dn) begin
            ram_raddr = x_ptr_inc[ADDR_W-1:0];
        end else if (i_cmd.rd_sel) begin
            ram_raddr = idx_ok ? x_pos[ADDR_W-1:0] : x_cnt_dec[ADDR_W-1:0];
        end
    end

    olst_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign x_found = (r_op != OP_SEARCH) ? '0 :
                     (scan_hit ? CMP_W'(r_scan_idx) : x_cnt);
    assign x_total = CMP_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_pend <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= i_cmd.finish;
            if (i_cmd.init_up || i_cmd.init_dn || i_cmd.init_scan) begin
                r_rd_pend <= 1'b0;
            end else if (i_cmd.step_up) begin
                r_rd_pend <= up_more;
            end else if (i_cmd.step_dn) begin
                r_rd_pend <= dn_more;
            end else if (i_cmd.step_scan) begin
                r_rd_pend <= scan_more;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_req.operation;
            r_pos  <= i_req.position;
            r_word <= vx[WORD_BITS-1:0];
        end
        if (i_cmd.init_up) begin
            r_ptr <= r_count;
        end else if (i_cmd.init_dn) begin
            r_ptr <= x_epos[CNT_W-1:0];
        end else if (i_cmd.init_scan) begin
            r_ptr <= '0;
        end else if (i_cmd.step_up && up_more) begin
            r_wr_addr <= r_ptr[ADDR_W-1:0];
            r_ptr     <= r_ptr - CNT_W'(1);
        end else if (i_cmd.step_dn && dn_more) begin
            r_wr_addr <= r_ptr[ADDR_W-1:0];
            r_ptr     <= r_ptr + CNT_W'(1);
        end else if (i_cmd.step_scan && scan_more) begin
            r_scan_idx <= r_ptr;
            r_ptr      <= r_ptr + CNT_W'(1);
        end
        if (i_cmd.finish) begin
            r_res.ok            <= i_cmd.ok;
            r_res.read_value    <= ((r_op == OP_SELECT) && (r_count != '0)) ?
                                   rx[31:0] : 32'sd0;
            r_res.found_index   <= x_found[RES_CNT_W-1:0];
            r_res.element_total <= x_total[RES_CNT_W-1:0];
            r_res.is_empty      <= (n_count == '0);
            r_res.is_full       <= (n_count == CNT_W'(CAPACITY));
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> $past(i_cmd.finish))
        else $error("entry count changed outside a finishing beat");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result beat held longer than one cycle");

endmodule

// ===== hdl/olst_ctrl.sv =====
// ----------------------------------------------------------------------------
// olst_ctrl
// Sequencer for the list: decodes the request, walks shifts and searches,
// and issues the finishing beat.
// ----------------------------------------------------------------------------
module olst_ctrl
    import olst_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output logic  o_busy,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SHUP  = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_SHDN  = 3'd4;
    localparam logic [2:0] S_SEL   = 3'd5;
    localparam logic [2:0] S_SCAN  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_IDLE;
                case (i_stat.op)
                    OP_INSERT, OP_INSERT_BACK: begin
                        if (i_stat.ins_ok) begin
                            o_cmd.init_up = 1'b1;
                            n_state       = S_SHUP;
                        end else begin
                            o_cmd.finish = 1'b1;
                        end
                    end
                    OP_REMOVE, OP_REMOVE_BACK: begin
                        if (i_stat.rem_ok) begin
                            o_cmd.init_dn = 1'b1;
                            n_state       = S_SHDN;
                        end else begin
                            o_cmd.finish = 1'b1;
                        end
                    end
                    OP_REPLACE: begin
                        o_cmd.wr_word = i_stat.idx_ok;
                        o_cmd.ok      = i_stat.idx_ok;
                        o_cmd.finish  = 1'b1;
                    end
                    OP_SELECT: begin
                        o_cmd.rd_sel = 1'b1;
                        n_state      = S_SEL;
                    end
                    OP_SEARCH: begin
                        o_cmd.init_scan = 1'b1;
                        n_state         = S_SCAN;
                    end
                    default: begin
                        o_cmd.finish = 1'b1;
                    end
                endcase
            end
            S_SHUP: begin
                o_cmd.step_up = 1'b1;
                if (!i_stat.up_more) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.wr_word = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                o_cmd.ok      = 1'b1;
                o_cmd.finish  = 1'b1;
                n_state       = S_IDLE;
            end
            S_SHDN: begin
                o_cmd.step_dn = 1'b1;
                if (!i_stat.dn_more) begin
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.ok      = 1'b1;
                    o_cmd.finish  = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_SEL: begin
                o_cmd.ok     = i_stat.idx_ok;
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.step_scan = 1'b1;
                if (i_stat.scan_hit || !i_stat.scan_more) begin
                    o_cmd.ok     = 1'b1;
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_start_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_CHECK))
        else $error("accepted request not decoded");

    a_finish_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == S_IDLE))
        else $error("sequencer not idle after finishing beat");

    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.step_up, o_cmd.step_dn, o_cmd.step_scan, o_cmd.wr_word}))
        else $error("conflicting RAM commands");

endmodule

// ===== hdl/ordered_array_list_top.sv =====
// ----------------------------------------------------------------------------
// ordered_array_list_top
// Ordered list of up to CAPACITY signed words with positional insert and
// remove, replace, select and search.
//
// Usage: a request beat (i_req) is taken at a clock edge where start is high
// and busy is low. busy rises the next cycle and stays high until the result
// is written. Each request yields exactly one result beat, shown on o_res
// for one cycle with o_strobe high; the receiver must take it then.
// Insert and insert back shift the entries from position p (the end for
// the back form) up by one, from the end downward, then write the word at
// p; remove and remove back shift the entries above p down by one. Search
// walks the entries from index 0, one entry per cycle, until a match or
// the end. Replace, select and rejected requests need no walk.
// Shifts and the search walk the entry RAM one entry per cycle through its
// single write and single read port. A new request may be taken in the
// cycle its predecessor's result is shown. Reset empties the list; RAM
// contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module ordered_array_list_top
    import olst_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_strobe,
    output t_res o_res
);

    t_cmd cmd;
    t_stat stat;

    olst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    olst_dpath #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule
